// ===== rtl/core/pfc_pkg.sv =====
// Shared widths, codes and types of the Playfair cipher block.
package pfc_pkg;

   localparam int KIND_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int LETTER_W = 7;
   localparam int IDX_W    = 5;
   localparam int CELL_W   = 5;

   localparam int NUM_LETTERS = 26;
   localparam int NUM_CELLS   = 25;

   localparam logic [IDX_W-1:0]    IDX_I      = 5'd8;
   localparam logic [IDX_W-1:0]    IDX_J      = 5'd9;
   localparam logic [IDX_W-1:0]    IDX_X      = 5'd23;
   localparam logic [IDX_W-1:0]    LAST_IDX   = 5'd25;
   localparam logic [CELL_W-1:0]   CELLS_FULL = 5'd25;
   localparam logic [LETTER_W-1:0] ASCII_A    = 7'd65;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR    = 3'd0,
      KIND_KEY      = 3'd1,
      KIND_KEY_END  = 3'd2,
      KIND_TEXT     = 3'd3,
      KIND_TEXT_END = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_POS_A,
      ST_POS_B,
      ST_CELL_A,
      ST_CELL_B,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
   } letter_type;

   typedef struct packed {
      logic [CELL_W-1:0] self_cell;
      logic [CELL_W-1:0] other_cell;
      logic              decrypt;
   } cell_req_type;

endpackage

// ===== rtl/core/pfc_if.sv =====
// Handshake channels of the Playfair cipher block: request, response and register write.
interface pfc_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfc_pkg::KIND_W-1:0]   kind;
   logic [pfc_pkg::BYTE_W-1:0]   byte_value;

   modport source (output valid, output kind, output byte_value, input ready);
   modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface pfc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfc_pkg::LETTER_W-1:0] first_letter;
   logic [pfc_pkg::LETTER_W-1:0] second_letter;
   logic                         has_pair;
   logic                         end_of_message;

   modport source (output valid, output first_letter, output second_letter,
                   output has_pair, output end_of_message, input ready);
   modport sink (input valid, input first_letter, input second_letter,
                 input has_pair, input end_of_message, output ready);
endinterface

interface pfc_csr_if;
   logic valid;
   logic ready;
   logic decrypt_mode;

   modport source (output valid, output decrypt_mode, input ready);
   modport sink (input valid, input decrypt_mode, output ready);
endinterface

// ===== rtl/core/pfc_cell_unit.sv =====
// Square cell arithmetic: maps one letter's cell to its enciphered cell.
module pfc_cell_unit (
   input  pfc_pkg::cell_req_type        cell_req,
   output logic [pfc_pkg::CELL_W-1:0]   cell_out
);
   import pfc_pkg::*;

   function automatic logic [2:0] row_of(input logic [CELL_W-1:0] cell_num);
      logic [8:0] prod;
      prod = {4'b0000, cell_num} * 9'd13;
      return prod[8:6];
   endfunction

   function automatic logic [2:0] col_of(input logic [CELL_W-1:0] cell_num,
                                         input logic [2:0] row);
      logic [CELL_W-1:0] base;
      logic [CELL_W-1:0] diff;
      base = {2'b00, row} * 5'd5;
      diff = cell_num - base;
      return diff[2:0];
   endfunction

   function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] step);
      logic [3:0] sum;
      logic [3:0] wrapped;
      sum     = {1'b0, v} + {1'b0, step};
      wrapped = sum - 4'd5;
      return (sum >= 4'd5) ? wrapped[2:0] : sum[2:0];
   endfunction

   logic [2:0] row_s;
   logic [2:0] col_s;
   logic [2:0] row_o;
   logic [2:0] col_o;
   logic [2:0] step;
   logic [2:0] row_r;
   logic [2:0] col_r;

   always_comb begin
      row_s = row_of(cell_req.self_cell);
      col_s = col_of(cell_req.self_cell, row_s);
      row_o = row_of(cell_req.other_cell);
      col_o = col_of(cell_req.other_cell, row_o);
      step  = cell_req.decrypt ? 3'd4 : 3'd1;
      priority if (row_s == row_o) begin
         row_r = row_s;
         col_r = add_mod5(col_s, step);
      end else if (col_s == col_o) begin
         row_r = add_mod5(row_s, step);
         col_r = col_s;
      end else begin
         row_r = row_s;
         col_r = col_o;
      end
      cell_out = ({2'b00, row_r} * 5'd5) + {2'b00, col_r};
   end

endmodule

// ===== rtl/core/playfair_cipher_top.sv =====
// Playfair cipher over a 5x5 key square, with key loading and streamed text.
//
// Request words carry a kind and a raw byte: clear key, key byte, key end,
// text byte and text end. Response words carry one enciphered letter pair,
// or on text end an end marker with or without a padded final pair. The
// register port sets encrypt or decrypt and is always ready.
// Clear key, key bytes, ignored words and the first letter of a pair are taken
// without leaving the idle state. Key end walks all 26 letters through the fill
// index. Text end with no pending letter goes straight to the emit state; a word
// that completes a pair reads both letter positions, works out both cells and
// then emits its response. The letter position memory and
// the key square memory each have one read port and are each read twice in
// turn, the shared cell unit working out one output cell per pass. The block
// accepts no request word while an item is in progress.
// A finished response is held in an output register, so the next request
// word is taken while it waits; if a second response is due before the first
// has been taken, the block waits in its emit state with request ready low.
// Reset selects encrypt mode, clears the key status and any pending letter;
// a new key must be loaded before text is processed.
module playfair_cipher_top (
   input  logic        clock,
   input  logic        reset,
   pfc_req_if.sink     req_chan,
   pfc_rsp_if.source   rsp_chan,
   pfc_csr_if.sink     csr_chan
);
   import pfc_pkg::*;

   function automatic letter_type filter_byte(input logic [BYTE_W-1:0] b);
      letter_type res;
      logic [BYTE_W-1:0] off;
      res = '0;
      priority if (b >= 8'd65 && b <= 8'd90) begin
         off       = b - 8'd65;
         res.valid = 1'b1;
         res.idx   = off[IDX_W-1:0];
      end else if (b >= 8'd97 && b <= 8'd122) begin
         off       = b - 8'd97;
         res.valid = 1'b1;
         res.idx   = off[IDX_W-1:0];
      end else begin
         off = '0;
      end
      if (res.idx == IDX_J) begin
         res.idx = IDX_I;
      end
      return res;
   endfunction

   state_type           state_ff, state_in;
   logic                decrypt_ff, decrypt_in;
   logic [25:0]         used_ff, used_in;
   logic [CELL_W-1:0]   fill_count_ff, fill_count_in;
   logic [IDX_W-1:0]    fill_idx_ff, fill_idx_in;
   logic [IDX_W-1:0]    pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                key_ready_ff, key_ready_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]    a_ff, a_in;
   logic [IDX_W-1:0]    b_ff, b_in;
   logic                pair_ff, pair_in;
   logic                end_ff, end_in;
   logic [CELL_W-1:0]   pa_ff, pa_in;
   logic [CELL_W-1:0]   pb_ff, pb_in;
   logic [IDX_W-1:0]    first_ff, first_in;
   logic [LETTER_W-1:0] rsp_first_ff, rsp_first_in;
   logic [LETTER_W-1:0] rsp_second_ff, rsp_second_in;
   logic                rsp_pair_ff, rsp_pair_in;
   logic                rsp_end_ff, rsp_end_in;

   logic [CELL_W-1:0]   pos_mem [NUM_LETTERS];
   logic [IDX_W-1:0]    ks_mem [NUM_CELLS];
   logic [CELL_W-1:0]   pos_rd_ff;
   logic [IDX_W-1:0]    ks_rd_ff;

   logic                req_ready;
   logic                req_fire;
   logic                csr_fire;
   logic                rsp_free;
   logic                emit_load;
   letter_type          letter;
   logic                place_en;
   logic [IDX_W-1:0]    place_idx;
   logic                pos_rd_en;
   logic [IDX_W-1:0]    pos_rd_addr;
   logic                ks_rd_en;
   logic [CELL_W-1:0]   ks_rd_addr;
   cell_req_type        cell_req;
   logic [CELL_W-1:0]   cell_out;

   pfc_cell_unit u_cell (
      .cell_req (cell_req),
      .cell_out (cell_out)
   );

   assign letter   = filter_byte(req_chan.byte_value);
   assign req_fire = req_chan.valid && req_ready;
   assign csr_fire = csr_chan.valid;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready         = req_ready;
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.first_letter  = rsp_first_ff;
   assign rsp_chan.second_letter = rsp_second_ff;
   assign rsp_chan.has_pair      = rsp_pair_ff;
   assign rsp_chan.end_of_message = rsp_end_ff;

   // Letter placement, from a key byte or from the fill walk.
   always_comb begin
      place_en  = 1'b0;
      place_idx = letter.idx;
      if (state_ff == ST_FILL) begin
         place_idx = fill_idx_ff;
         place_en  = !used_ff[fill_idx_ff] && (fill_count_ff < CELLS_FULL);
      end else if (req_fire && req_chan.kind == KIND_KEY) begin
         place_en = !key_ready_ff && letter.valid && !used_ff[letter.idx] &&
                    (fill_count_ff < CELLS_FULL);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_chan.kind == KIND_KEY_END) begin
                  state_in = ST_FILL;
               end else if (req_chan.kind == KIND_TEXT) begin
                  if (key_ready_ff && letter.valid && pend_valid_ff) begin
                     state_in = ST_POS_A;
                  end
               end else if (req_chan.kind == KIND_TEXT_END) begin
                  state_in = (key_ready_ff && pend_valid_ff) ? ST_POS_A : ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            if (fill_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_POS_A:  state_in = ST_POS_B;
         ST_POS_B:  state_in = ST_CELL_A;
         ST_CELL_A: state_in = ST_CELL_B;
         ST_CELL_B: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      pos_rd_en   = 1'b0;
      pos_rd_addr = a_ff;
      ks_rd_en    = 1'b0;
      ks_rd_addr  = cell_out;
      emit_load   = 1'b0;
      cell_req.decrypt    = decrypt_ff;
      cell_req.self_cell  = (state_ff == ST_CELL_B) ? pb_ff : pa_ff;
      cell_req.other_cell = (state_ff == ST_CELL_B) ? pa_ff : pos_rd_ff;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FILL:   req_ready = 1'b0;
         ST_POS_A: begin
            pos_rd_en   = 1'b1;
            pos_rd_addr = a_ff;
         end
         ST_POS_B: begin
            pos_rd_en   = 1'b1;
            pos_rd_addr = b_ff;
         end
         ST_CELL_A: ks_rd_en = 1'b1;
         ST_CELL_B: ks_rd_en = 1'b1;
         ST_EMIT:   emit_load = rsp_free;
         default:   req_ready = 1'b0;
      endcase
   end

   always_comb begin
      decrypt_in    = csr_fire ? csr_chan.decrypt_mode : decrypt_ff;
      used_in       = used_ff;
      fill_count_in = fill_count_ff;
      fill_idx_in   = fill_idx_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      key_ready_in  = key_ready_ff;
      rsp_valid_in  = rsp_valid_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pair_in       = pair_ff;
      end_in        = end_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      first_in      = first_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_end_in    = rsp_end_ff;

      if (place_en) begin
         used_in[place_idx] = 1'b1;
         fill_count_in      = fill_count_ff + 5'd1;
      end

      if (state_ff == ST_FILL) begin
         fill_idx_in = fill_idx_ff + 5'd1;
         if (fill_idx_ff == LAST_IDX) begin
            key_ready_in = 1'b1;
         end
      end

      if (req_fire) begin
         unique case (req_chan.kind)
            KIND_CLEAR: begin
               used_in        = '0;
               used_in[IDX_J] = 1'b1;
               fill_count_in  = '0;
               key_ready_in   = 1'b0;
               pend_in        = '0;
               pend_valid_in  = 1'b0;
            end
            KIND_KEY_END: fill_idx_in = '0;
            KIND_TEXT: begin
               if (key_ready_ff && letter.valid) begin
                  if (!pend_valid_ff) begin
                     pend_in       = letter.idx;
                     pend_valid_in = 1'b1;
                  end else begin
                     a_in    = pend_ff;
                     pair_in = 1'b1;
                     end_in  = 1'b0;
                     if (!decrypt_ff && letter.idx == pend_ff) begin
                        b_in    = IDX_X;
                        pend_in = letter.idx;
                     end else begin
                        b_in          = letter.idx;
                        pend_valid_in = 1'b0;
                     end
                  end
               end
            end
            KIND_TEXT_END: begin
               a_in          = pend_ff;
               b_in          = IDX_X;
               pair_in       = key_ready_ff && pend_valid_ff;
               end_in        = 1'b1;
               pend_in       = '0;
               pend_valid_in = 1'b0;
            end
            default: pend_in = pend_ff;
         endcase
      end

      if (state_ff == ST_POS_B) begin
         pa_in = pos_rd_ff;
      end
      if (state_ff == ST_CELL_A) begin
         pb_in = pos_rd_ff;
      end
      if (state_ff == ST_CELL_B) begin
         first_in = ks_rd_ff;
      end

      if (emit_load) begin
         rsp_valid_in  = 1'b1;
         rsp_first_in  = pair_ff ? (ASCII_A + {2'b00, first_ff}) : '0;
         rsp_second_in = pair_ff ? (ASCII_A + {2'b00, ks_rd_ff}) : '0;
         rsp_pair_in   = pair_ff;
         rsp_end_in    = end_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         decrypt_ff     <= 1'b0;
         used_ff        <= 26'd1 << IDX_J;
         fill_count_ff  <= '0;
         fill_idx_ff    <= '0;
         pend_ff        <= '0;
         pend_valid_ff  <= 1'b0;
         key_ready_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         decrypt_ff    <= decrypt_in;
         used_ff       <= used_in;
         fill_count_ff <= fill_count_in;
         fill_idx_ff   <= fill_idx_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         key_ready_ff  <= key_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      pair_ff       <= pair_in;
      end_ff        <= end_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      first_ff      <= first_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // Letter position and key square memories, one read port each.
   always_ff @(posedge clock) begin
      if (place_en) begin
         pos_mem[place_idx]    <= fill_count_ff;
         ks_mem[fill_count_ff] <= place_idx;
      end
      if (pos_rd_en) begin
         pos_rd_ff <= pos_mem[pos_rd_addr];
      end
      if (ks_rd_en) begin
         ks_rd_ff <= ks_mem[ks_rd_addr];
      end
   end

`ifndef ASSERT_OFF
   a_fill_count_tracks_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == (int'(fill_count_ff) + 1))
      else $error("fill count does not match the number of placed letters");

   a_fill_completes_square: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && fill_idx_ff == LAST_IDX) |=>
      (key_ready_ff && fill_count_ff == CELLS_FULL))
      else $error("key square not full when the fill walk ends");

   a_empty_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pair_ff) |-> (rsp_first_ff == '0 && rsp_second_ff == '0))
      else $error("response without a pair carries letters");

   a_text_end_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.kind == KIND_TEXT_END) |=> !pend_valid_ff)
      else $error("pending letter survives a text end word");
`endif

endmodule
